@@ hdl/double_ended_priority_queue_core_macros.svh @@
// assertion macros used by the queue top level
`ifndef DOUBLE_ENDED_PRIORITY_QUEUE_CORE_MACROS_SVH
`define DOUBLE_ENDED_PRIORITY_QUEUE_CORE_MACROS_SVH
`ifndef SYNTHESIS
// property checked while out of reset
`define DEPQ_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("depq assertion failed");
// property checked at every edge, reset included
`define DEPQ_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("depq assertion failed");
`else
`define DEPQ_ASSERT(lbl, clk, rst_n, prop)
`define DEPQ_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

@@ hdl/depq_pkg.sv @@
// types, operation codes and helpers for the double-ended priority queue
package depq_pkg;

    // operation codes carried by an input word
    typedef enum logic [1:0] {
        MODE_INSERT  = 2'd0,
        MODE_DEL_MAX = 2'd1,
        MODE_DEL_MIN = 2'd2,
        MODE_CLEAR   = 2'd3
    } t_mode;

    // update request from the control logic to the sorted array
    typedef struct packed {
        logic load;     // insert i_value at its sorted place
        logic shift;    // drop the smallest entry, move the rest down
    } t_shift_ctl;

    localparam int unsigned DATA_W = 32;

    // flip the sign bit so an unsigned compare follows signed order
    function automatic logic [DATA_W-1:0] order_key(input logic [DATA_W-1:0] raw);
        order_key = {~raw[DATA_W-1], raw[DATA_W-2:0]};
    endfunction

endpackage

@@ hdl/depq_sorted_array.sv @@
// register-held sorted array with parallel insert/shift and end readout
module depq_sorted_array #(
    parameter int CAPACITY = 64
) (
    input  logic                        i_clk,
    input  depq_pkg::t_shift_ctl        i_ctl,
    input  logic [depq_pkg::DATA_W-1:0] i_value,
    input  logic [CAPACITY-1:0]         i_valid,
    output logic [depq_pkg::DATA_W-1:0] o_max,
    output logic [depq_pkg::DATA_W-1:0] o_min
);
    import depq_pkg::*;

    logic [DATA_W-1:0] r_entries [CAPACITY];
    logic [DATA_W-1:0] n_entries [CAPACITY];
    logic [CAPACITY-1:0] w_ge;
    logic [CAPACITY-1:0] w_last;
    logic [DATA_W-1:0] w_max_sel;
    logic [DATA_W-1:0] w_value_key;

    // thermometer of places at or after the insert point
    always_comb begin
        w_value_key = order_key(i_value);
        for (int i = 0; i < CAPACITY; i++) begin
            w_ge[i] = !i_valid[i] || (order_key(r_entries[i]) > w_value_key);
        end
    end

    // next contents: each place picks keep, new word, left or right neighbor
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            n_entries[i] = r_entries[i];
            if (i_ctl.load && w_ge[i]) begin
                if (i == 0) begin
                    n_entries[i] = i_value;
                end else if (!w_ge[i-1]) begin
                    n_entries[i] = i_value;
                end else begin
                    n_entries[i] = r_entries[i-1];
                end
            end else if (i_ctl.shift && (i < CAPACITY - 1)) begin
                n_entries[i] = r_entries[i+1];
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_ctl.load || i_ctl.shift) begin
            for (int i = 0; i < CAPACITY; i++) begin
                r_entries[i] <= n_entries[i];
            end
        end
    end

    // one-hot of the last valid place, and-or select of the largest
    always_comb begin
        w_max_sel = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (i == CAPACITY - 1) begin
                w_last[i] = i_valid[i];
            end else begin
                w_last[i] = i_valid[i] && !i_valid[i+1];
            end
            w_max_sel = w_max_sel | (r_entries[i] & {DATA_W{w_last[i]}});
        end
    end

    // registered end values, zero when empty
    always_ff @(posedge i_clk) begin
        o_max <= w_max_sel;
        o_min <= i_valid[0] ? r_entries[0] : '0;
    end

endmodule

@@ hdl/double_ended_priority_queue_core.sv @@
// top level of the double-ended priority queue
//
// Command channel: a word (i_mode, i_value) is taken at a rising edge where
// start is high and busy is low. busy is held low, so a word may be issued
// in every cycle: throughput is one operation per clock.
// Operations: insert, delete one copy of the largest, delete one copy of the
// smallest, clear. Deletes on an empty queue change nothing; an insert into
// a full queue is dropped and flagged on o_overflow.
// Result channel: o_valid is high for exactly one cycle per command, after
// the array and then the output registers have taken the command, with the
// largest and smallest held values (zero when empty), the count (low 7 bits)
// and the empty flag. First the sorted register array is updated by a
// parallel compare and shift over all CAPACITY places; then the end entries
// are picked out of the array into the output registers. The receiver cannot
// stall: every result is shown once and must be taken in that cycle.
// Reset (synchronous, active low) empties the queue and drops results in
// flight; stored words are not cleared, only the count.
module double_ended_priority_queue_core #(
    parameter int CAPACITY = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_mode,
    input  logic signed [31:0] i_value,
    output logic               o_valid,
    output logic signed [31:0] o_max_value,
    output logic signed [31:0] o_min_value,
    output logic [6:0]         o_entry_count,
    output logic               o_is_empty,
    output logic               o_overflow
);
    import depq_pkg::*;

    `include "double_ended_priority_queue_core_macros.svh"

    localparam int CW = $clog2(CAPACITY + 1);

    logic          w_accept;
    t_mode         w_mode;
    t_shift_ctl    w_ctl;
    logic          w_full;
    logic          w_empty;
    logic          w_drop;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [CAPACITY-1:0] w_valid;
    logic          r_s1_valid;
    logic          r_s1_ovf;
    logic [31:0]   w_count_ext;
    logic [DATA_W-1:0] w_arr_max;
    logic [DATA_W-1:0] w_arr_min;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;
    assign w_mode   = t_mode'(i_mode);
    assign w_full   = (r_count == CW'(CAPACITY));
    assign w_empty  = (r_count == '0);

    // command decode
    always_comb begin
        w_ctl   = '0;
        w_drop  = 1'b0;
        n_count = r_count;
        if (w_accept) begin
            unique case (w_mode)
                MODE_INSERT: begin
                    if (w_full) begin
                        w_drop = 1'b1;
                    end else begin
                        w_ctl.load = 1'b1;
                        n_count    = r_count + 1'b1;
                    end
                end
                MODE_DEL_MAX: begin
                    if (!w_empty) begin
                        n_count = r_count - 1'b1;
                    end
                end
                MODE_DEL_MIN: begin
                    if (!w_empty) begin
                        w_ctl.shift = 1'b1;
                        n_count     = r_count - 1'b1;
                    end
                end
                MODE_CLEAR: begin
                    n_count = '0;
                end
                default: begin
                    n_count = r_count;
                end
            endcase
        end
    end

    // valid places below the count
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            w_valid[i] = (32'(r_count) > 32'(i));
        end
    end

    // count and first-stage flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_s1_valid <= 1'b0;
            r_s1_ovf   <= 1'b0;
        end else begin
            r_count    <= n_count;
            r_s1_valid <= w_accept;
            r_s1_ovf   <= w_drop;
        end
    end

    depq_sorted_array #(
        .CAPACITY (CAPACITY)
    ) u_array (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_value (i_value),
        .i_valid (w_valid),
        .o_max   (w_arr_max),
        .o_min   (w_arr_min)
    );

    assign w_count_ext = 32'(r_count);

    // result word registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_s1_valid;
        end
        o_overflow    <= r_s1_ovf;
        o_entry_count <= w_count_ext[6:0];
        o_is_empty    <= w_empty;
    end

    assign o_max_value = w_arr_max;
    assign o_min_value = w_arr_min;

    // checks
    `DEPQ_ASSERT(a_count_bound, i_clk, i_rst_n, 32'(r_count) <= 32'(CAPACITY))
    `DEPQ_ASSERT(a_ovf_needs_full, i_clk, i_rst_n, (w_accept && w_drop) |-> w_full)
    `DEPQ_ASSERT(a_result_follows, i_clk, i_rst_n, w_accept |=> ##1 o_valid)
    `DEPQ_ASSERT(a_empty_zero, i_clk, i_rst_n,
        (o_valid && o_is_empty) |-> (o_max_value == 0 && o_min_value == 0))
    `DEPQ_ASSERT(a_order, i_clk, i_rst_n,
        (o_valid && !o_is_empty) |-> (o_max_value >= o_min_value))
    `DEPQ_ASSERT_ALWAYS(a_never_busy, i_clk, !busy)

endmodule

@@ verif/double_ended_priority_queue_core_test.sv @@
`timescale 1ns / 100ps
// self-checking testbench for the double-ended priority queue core
module double_ended_priority_queue_core_test;
    import depq_pkg::*;

    localparam int QUEUE_DEPTH  = 64;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_WORDS = 400;
    localparam int QUIET_TAIL   = 100;
    localparam logic signed [31:0] VALUE_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] VALUE_MIN = 32'sh80000000;

    // one status report of the queue
    typedef struct packed {
        logic [31:0] max_value;
        logic [31:0] min_value;
        logic [6:0]  entry_count;
        logic        is_empty;
        logic        overflow;
    } t_status;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start   = 1'b0;
    logic               busy;
    logic [1:0]         i_mode  = MODE_INSERT;
    logic signed [31:0] i_value = '0;
    logic               o_valid;
    logic signed [31:0] o_max_value;
    logic signed [31:0] o_min_value;
    logic [6:0]         o_entry_count;
    logic               o_is_empty;
    logic               o_overflow;

    // sorted copy of the queue contents, ascending
    logic signed [31:0] held_values [QUEUE_DEPTH];
    int                 held_count = 0;
    t_status            pending_status[$];
    t_status            observed_status;
    t_status            wanted_status;
    int                 error_count = 0;
    int                 cycle_count = 0;
    bit                 gaps_on     = 1'b1;

    double_ended_priority_queue_core #(
        .CAPACITY(QUEUE_DEPTH)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_mode       (i_mode),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .o_max_value  (o_max_value),
        .o_min_value  (o_min_value),
        .o_entry_count(o_entry_count),
        .o_is_empty   (o_is_empty),
        .o_overflow   (o_overflow)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     pending_status.size());
            $display("FAILURE");
            $finish;
        end
    end

    // apply one operation to the sorted copy and queue the status it reports
    task automatic update_queue_model(input t_mode op, input logic signed [31:0] v);
        int      pos;
        t_status st;
        st = '0;
        case (op)
            MODE_INSERT: begin
                if (held_count >= QUEUE_DEPTH) begin
                    st.overflow = 1'b1;
                end else begin
                    // equal values stay ahead of the new one
                    pos = held_count;
                    while (pos > 0 && held_values[pos-1] > v) begin
                        held_values[pos] = held_values[pos-1];
                        pos--;
                    end
                    held_values[pos] = v;
                    held_count++;
                end
            end
            MODE_DEL_MAX: begin
                if (held_count > 0)
                    held_count--;
            end
            MODE_DEL_MIN: begin
                if (held_count > 0) begin
                    for (pos = 1; pos < held_count; pos++)
                        held_values[pos-1] = held_values[pos];
                    held_count--;
                end
            end
            default: begin
                held_count = 0;
            end
        endcase
        if (held_count != 0) begin
            st.max_value = held_values[held_count-1];
            st.min_value = held_values[0];
        end
        st.entry_count = 7'(held_count);
        st.is_empty    = (held_count == 0);
        pending_status.push_back(st);
    endtask

    // issue one word, with an occasional gap ahead of it
    task automatic send_word(input t_mode op, input logic signed [31:0] v);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        start   <= 1'b1;
        i_mode  <= op;
        i_value <= v;
        @(posedge i_clk);
        while (busy !== 1'b0)
            @(posedge i_clk);
        update_queue_model(op, v);
    endtask

    task automatic report_mismatch(input string field, input longint want,
                                   input longint got);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        error_count++;
    endtask

    // compare each result word with the oldest pending status
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1) begin
            observed_status = {o_max_value, o_min_value, o_entry_count, o_is_empty,
                               o_overflow};
            if (pending_status.size() == 0) begin
                $display("%0t: unexpected result word, max %0d min %0d count %0d",
                         $time, o_max_value, o_min_value, o_entry_count);
                error_count++;
            end else begin
                wanted_status = pending_status.pop_front();
                if (observed_status.max_value !== wanted_status.max_value)
                    report_mismatch("max_value", $signed(wanted_status.max_value),
                                    $signed(observed_status.max_value));
                if (observed_status.min_value !== wanted_status.min_value)
                    report_mismatch("min_value", $signed(wanted_status.min_value),
                                    $signed(observed_status.min_value));
                if (observed_status.entry_count !== wanted_status.entry_count)
                    report_mismatch("entry_count", wanted_status.entry_count,
                                    observed_status.entry_count);
                if (observed_status.is_empty !== wanted_status.is_empty)
                    report_mismatch("is_empty", wanted_status.is_empty,
                                    observed_status.is_empty);
                if (observed_status.overflow !== wanted_status.overflow)
                    report_mismatch("overflow", wanted_status.overflow,
                                    observed_status.overflow);
            end
        end
    end

    // deletes on empty, extreme values, duplicates, clear
    task automatic test_directed_corners();
        send_word(MODE_DEL_MAX, 32'sd0);
        send_word(MODE_DEL_MIN, 32'sd0);
        send_word(MODE_INSERT, VALUE_MAX);
        send_word(MODE_INSERT, VALUE_MIN);
        send_word(MODE_INSERT, 32'sd0);
        send_word(MODE_INSERT, -32'sd1);
        send_word(MODE_INSERT, 32'sd1);
        send_word(MODE_INSERT, 32'sd5);
        send_word(MODE_INSERT, 32'sd5);
        send_word(MODE_INSERT, -32'sd1);
        send_word(MODE_DEL_MAX, 32'sd0);
        send_word(MODE_DEL_MAX, 32'sd0);
        send_word(MODE_DEL_MIN, 32'sd0);
        send_word(MODE_DEL_MIN, 32'sd0);
        send_word(MODE_INSERT, 32'sh55555555);
        send_word(MODE_INSERT, 32'shaaaaaaaa);
        send_word(MODE_DEL_MAX, 32'sd0);
        send_word(MODE_CLEAR, 32'sh12345678);
        send_word(MODE_DEL_MIN, 32'sd0);
        send_word(MODE_DEL_MAX, 32'sd0);
        send_word(MODE_INSERT, 32'sd7);
        send_word(MODE_DEL_MIN, 32'sd0);
        send_word(MODE_CLEAR, 32'sd0);
    endtask

    // fill to capacity with many duplicates, then push past full
    task automatic test_fill_to_capacity();
        int n;
        for (n = 0; n < QUEUE_DEPTH; n++)
            send_word(MODE_INSERT, $signed(32'($urandom_range(0, 20))) - 32'sd10);
        send_word(MODE_INSERT, VALUE_MAX);
        send_word(MODE_INSERT, VALUE_MIN);
        send_word(MODE_INSERT, 32'sd3);
        send_word(MODE_DEL_MIN, 32'sd0);
        send_word(MODE_INSERT, VALUE_MIN);
        send_word(MODE_INSERT, VALUE_MAX);
        send_word(MODE_DEL_MAX, 32'sd0);
        send_word(MODE_DEL_MAX, 32'sd0);
        send_word(MODE_CLEAR, 32'sd0);
    endtask

    // mixed operations; the insert share drifts per segment so the fill level
    // swings between empty and full
    task automatic test_random_traffic();
        int                 n;
        int                 roll;
        int                 insert_pct;
        t_mode              op;
        logic signed [31:0] v;
        insert_pct = 60;
        for (n = 0; n < RANDOM_WORDS; n++) begin
            if (n % 50 == 0)
                insert_pct = $urandom_range(25, 85);
            gaps_on = (n < RANDOM_WORDS - QUIET_TAIL);
            roll = $urandom_range(0, 99);
            if (roll < 2)
                op = MODE_CLEAR;
            else if (roll < 2 + insert_pct)
                op = MODE_INSERT;
            else if ($urandom_range(0, 1) == 0)
                op = MODE_DEL_MAX;
            else
                op = MODE_DEL_MIN;
            case ($urandom_range(0, 3))
                0: v = $signed(32'($urandom_range(0, 16))) - 32'sd8;
                1: v = ($urandom_range(0, 1) == 0) ?
                       VALUE_MAX - $signed(32'($urandom_range(0, 3))) :
                       VALUE_MIN + $signed(32'($urandom_range(0, 3)));
                default: v = $signed($urandom);
            endcase
            send_word(op, v);
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_corners();
        test_fill_to_capacity();
        test_random_traffic();
        start <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
